@@ hdl/pepm_pkg.sv @@
`default_nettype none
package pepm_pkg;
   localparam int unsigned WORD_BITS = 64;
   localparam logic [0:0] REG_MODULUS = 1'b0;
   localparam logic [0:0] REG_EVAL_POINT = 1'b1;

   typedef struct packed {
      logic [15:0] outer;
      logic [15:0] middle;
      logic [7:0] inner;
      logic [63:0] coeff;
      logic last;
   } term_type;

   typedef struct packed {
      logic [15:0] outer;
      logic [15:0] middle;
      logic [63:0] value_plus;
      logic [63:0] value_minus;
      logic done;
   } result_type;

   // modular add of two values already below n (65-bit sum)
   function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] n);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, n}) s = s - {1'b0, n};
      return s[63:0];
   endfunction

   function automatic logic [63:0] sub_mod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] n);
      return (a >= b) ? (a - b) : (a + (n - b));
   endfunction
endpackage
`default_nettype wire

@@ hdl/pepm_modred.sv @@
`default_nettype none
// iterative reduction a mod n, one quotient bit per cycle (restoring)
module pepm_modred import pepm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [63:0] a,
   input wire logic [63:0] n,
   output logic busy,
   output logic [63:0] r
);
   logic [64:0] rem_ff, rem_in;
   logic [63:0] sh_ff, sh_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [64:0] t;

   always_comb begin
      rem_in = rem_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      t = {rem_ff[63:0], sh_ff[63]};
      if (start) begin
         rem_in = '0;
         sh_in = a;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (t >= {1'b0, n}) t = t - {1'b0, n};
         rem_in = t;
         sh_in = {sh_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff <= sh_in;
   end

   assign busy = busy_ff;
   assign r = rem_ff[63:0];
endmodule
`default_nettype wire

@@ hdl/pepm_mulmod.sv @@
`default_nettype none
// shift-add modular multiply, one multiplier bit per cycle, operands below n
module pepm_mulmod import pepm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [63:0] a,
   input wire logic [63:0] b,
   input wire logic [63:0] n,
   output logic busy,
   output logic [63:0] r
);
   logic [63:0] acc_ff, acc_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] a_ff, a_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [63:0] d;

   always_comb begin
      acc_in = acc_ff;
      b_in = b_ff;
      a_in = a_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      d = add_mod(acc_ff, acc_ff, n);
      if (b_ff[63]) d = add_mod(d, a_ff, n);
      if (start) begin
         acc_in = '0;
         a_in = a;
         b_in = b;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = d;
         b_in = {b_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign busy = busy_ff;
   assign r = acc_ff;
endmodule
`default_nettype wire

@@ hdl/pepm_front.sv @@
`default_nettype none
// input side: masks and saturates exponents, queues terms for the back end
module pepm_front import pepm_pkg::*; #(
   parameter int unsigned INNER_DEG_MAX = 255,
   parameter int unsigned EXP_FIELD_BITS = 16,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire term_type in_term,
   output logic out_valid,
   input wire logic out_ready,
   output term_type out_term
);
   localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned EXP_KEEP = (EXP_FIELD_BITS < 16) ? EXP_FIELD_BITS : 16;
   localparam logic [15:0] EXP_MASK = 16'((32'd1 << EXP_KEEP) - 32'd1);
   localparam int unsigned INNER_SAT = (INNER_DEG_MAX < 255) ? INNER_DEG_MAX : 255;
   localparam logic [7:0] INNER_LIM = 8'(INNER_SAT);

   term_type q_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [PTR_BITS:0] cnt_ff;
   term_type t;
   logic push, pop;

   always_comb begin
      t = in_term;
      t.outer = in_term.outer & EXP_MASK;
      t.middle = in_term.middle & EXP_MASK;
      if (in_term.inner > INNER_LIM) t.inner = INNER_LIM;
   end

   assign in_ready = (cnt_ff != (PTR_BITS+1)'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_term = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
      end
      if (push) q_ff[wr_ff] <= t;
   end
endmodule
`default_nettype wire

@@ hdl/pepm_back.sv @@
`default_nettype none
// execution side: power table, modular multiply, group sums and result register
module pepm_back import pepm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic [63:0] modulus,
   input wire logic [63:0] eval_point,
   input wire logic table_clear,
   input wire logic in_valid,
   output logic in_ready,
   input wire term_type in_term,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output result_type rsp_data,
   output logic idle
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RED_A = 4'd1;
   localparam logic [3:0] S_RED_B = 4'd2;
   localparam logic [3:0] S_EMIT_OLD = 4'd3;
   localparam logic [3:0] S_POW = 4'd4;
   localparam logic [3:0] S_POW_RD = 4'd5;
   localparam logic [3:0] S_EXT = 4'd6;
   localparam logic [3:0] S_EXT_W = 4'd7;
   localparam logic [3:0] S_MUL = 4'd8;
   localparam logic [3:0] S_MUL_W = 4'd9;
   localparam logic [3:0] S_EMIT_LAST = 4'd10;
   localparam logic [3:0] S_RED_SUM = 4'd11;
   localparam logic [3:0] S_RED_SUM_W = 4'd12;
   localparam logic [3:0] S_RED_ODD_W = 4'd13;

   logic [3:0] st_ff;
   logic [63:0] n_eff;
   logic [63:0] pow_mem [256];
   logic [63:0] pow_rd_ff;
   logic [63:0] alpha_ff, coeff_ff, pw_ff, prod;
   logic [8:0] filled_ff;
   logic [15:0] cur_outer_ff, cur_middle_ff;
   logic have_ff;
   logic [63:0] even_ff, odd_ff;
   logic [1:0] red_sel_ff;
   term_type term_ff;
   logic rsp_valid_ff;
   result_type rsp_ff;
   logic red_start, mul_start, red_busy, mul_busy;
   logic [63:0] red_a, red_r, mul_a, mul_b, mul_r;
   logic [7:0] pow_addr;
   logic pow_we;
   logic [7:0] pow_waddr;
   logic [63:0] pow_wdata;
   logic sums_ok_ff;

   assign n_eff = (modulus == 64'd0) ? 64'd1 : modulus;

   pepm_modred u_red (.clock, .reset, .start(red_start), .a(red_a), .n(n_eff),
      .busy(red_busy), .r(red_r));
   pepm_mulmod u_mul (.clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
      .n(n_eff), .busy(mul_busy), .r(mul_r));

   assign prod = mul_r;
   assign in_ready = (st_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign idle = (st_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      red_start = 1'b0;
      red_a = 64'd0;
      mul_start = 1'b0;
      mul_a = pw_ff;
      mul_b = coeff_ff;
      pow_we = 1'b0;
      pow_waddr = filled_ff[7:0];
      pow_wdata = 64'd0;
      pow_addr = term_ff.inner;
      case (st_ff)
         S_IDLE: begin
            if (in_valid && !rsp_valid_ff) begin
               red_start = 1'b1;
               red_a = in_term.coeff;
            end
         end
         S_RED_A: begin
            if (!red_busy) begin
               red_start = 1'b1;
               red_a = eval_point;
            end
         end
         S_RED_SUM: begin
            red_start = 1'b1;
            red_a = red_sel_ff[0] ? odd_ff : even_ff;
         end
         S_POW: begin
            if (filled_ff == 9'd0) begin
               pow_we = 1'b1;
               pow_wdata = (n_eff == 64'd1) ? 64'd0 : 64'd1;
            end else if (filled_ff == 9'd1) begin
               pow_we = 1'b1;
               pow_wdata = alpha_ff;
            end
         end
         S_EXT: begin
            mul_start = 1'b1;
            mul_a = pow_rd_ff;
            mul_b = alpha_ff;
         end
         S_EXT_W: begin
            if (!mul_busy) begin
               pow_we = 1'b1;
               pow_wdata = mul_r;
            end
         end
         S_MUL: mul_start = 1'b1;
         default: ;
      endcase
      // while extending, read the highest filled entry; otherwise the term's power
      if ((st_ff == S_POW || st_ff == S_POW_RD) && filled_ff > 9'd1
          && filled_ff <= {1'b0, term_ff.inner}) pow_addr = 8'(filled_ff - 9'd1);
   end

   always_ff @(posedge clock) begin
      if (pow_we) pow_mem[pow_waddr] <= pow_wdata;
      pow_rd_ff <= pow_mem[pow_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         filled_ff <= '0;
         have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         even_ff <= '0;
         odd_ff <= '0;
         cur_outer_ff <= '0;
         cur_middle_ff <= '0;
         sums_ok_ff <= 1'b1;
         red_sel_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (table_clear) begin
            filled_ff <= '0;
            sums_ok_ff <= 1'b0;
         end
         case (st_ff)
            S_IDLE: begin
               if (in_valid && !rsp_valid_ff) begin
                  term_ff <= in_term;
                  st_ff <= S_RED_A;
               end
            end
            S_RED_A: begin
               if (!red_busy) begin
                  coeff_ff <= red_r;
                  st_ff <= S_RED_B;
               end
            end
            S_RED_B: begin
               if (!red_busy) begin
                  alpha_ff <= red_r;
                  // sums from before a register write get reduced under the new n
                  if (!sums_ok_ff && have_ff) begin
                     red_sel_ff <= 2'd0;
                     st_ff <= S_RED_SUM;
                  end else begin
                     sums_ok_ff <= 1'b1;
                     st_ff <= S_EMIT_OLD;
                  end
               end
            end
            S_RED_SUM: st_ff <= S_RED_SUM_W;
            S_RED_SUM_W: begin
               if (!red_busy) begin
                  if (!red_sel_ff[0]) begin
                     even_ff <= red_r;
                     red_sel_ff <= 2'd1;
                     st_ff <= S_RED_SUM;
                  end else begin
                     odd_ff <= red_r;
                     st_ff <= S_RED_ODD_W;
                  end
               end
            end
            S_RED_ODD_W: begin
               sums_ok_ff <= 1'b1;
               st_ff <= S_EMIT_OLD;
            end
            S_EMIT_OLD: begin
               if (have_ff && (term_ff.outer != cur_outer_ff
                               || term_ff.middle != cur_middle_ff)) begin
                  if (!rsp_valid_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff.outer <= cur_outer_ff;
                     rsp_ff.middle <= cur_middle_ff;
                     rsp_ff.value_plus <= add_mod(even_ff, odd_ff, n_eff);
                     rsp_ff.value_minus <= sub_mod(even_ff, odd_ff, n_eff);
                     rsp_ff.done <= 1'b0;
                     have_ff <= 1'b0;
                  end
               end else begin
                  if (!have_ff) begin
                     cur_outer_ff <= term_ff.outer;
                     cur_middle_ff <= term_ff.middle;
                     even_ff <= '0;
                     odd_ff <= '0;
                     have_ff <= 1'b1;
                  end
                  st_ff <= S_POW;
               end
            end
            S_POW: begin
               if (filled_ff <= {1'b0, term_ff.inner}) begin
                  if (filled_ff < 9'd2) filled_ff <= filled_ff + 9'd1;
                  else st_ff <= S_POW_RD;
               end else begin
                  st_ff <= S_POW_RD;
               end
            end
            S_POW_RD: begin
               if (filled_ff <= {1'b0, term_ff.inner}) st_ff <= S_EXT;
               else begin
                  pw_ff <= pow_rd_ff;
                  st_ff <= S_MUL;
               end
            end
            S_EXT: st_ff <= S_EXT_W;
            S_EXT_W: begin
               if (!mul_busy) begin
                  filled_ff <= filled_ff + 9'd1;
                  st_ff <= S_POW;
               end
            end
            S_MUL: st_ff <= S_MUL_W;
            S_MUL_W: begin
               if (!mul_busy) begin
                  if (term_ff.inner[0]) odd_ff <= add_mod(odd_ff, prod, n_eff);
                  else even_ff <= add_mod(even_ff, prod, n_eff);
                  st_ff <= term_ff.last ? S_EMIT_LAST : S_IDLE;
               end
            end
            S_EMIT_LAST: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.outer <= cur_outer_ff;
                  rsp_ff.middle <= cur_middle_ff;
                  rsp_ff.value_plus <= add_mod(even_ff, odd_ff, n_eff);
                  rsp_ff.value_minus <= sub_mod(even_ff, odd_ff, n_eff);
                  rsp_ff.done <= 1'b1;
                  have_ff <= 1'b0;
                  even_ff <= '0;
                  odd_ff <= '0;
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hdl/poly_eval_plus_minus_point_top.sv @@
`default_nettype none
// evaluates each (outer, middle) group of a sparse polynomial mod n at +alpha and -alpha.
// terms enter a short input queue (front) and are worked one at a time by the back end,
// whose rate is set by its bit-serial units: a reduction of the coefficient and of alpha,
// then a shift-add modular multiply, plus power-table entries built the first time a
// higher inner exponent is seen, and a reduction of the open group's sums after a register
// write. a finished group is held in the result register; up to two results follow one
// term (closed group, then the final group on the last term). register writes rebuild
// the power table on demand.
module poly_eval_plus_minus_point_top import pepm_pkg::*; #(
   parameter int unsigned INNER_DEG_MAX = 255,
   parameter int unsigned EXP_FIELD_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   // term input
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [15:0] req_term_outer,
   input wire logic [15:0] req_term_middle,
   input wire logic [7:0] req_term_inner,
   input wire logic [63:0] req_term_coeff,
   input wire logic req_term_last,
   // group results
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [15:0] rsp_group_outer,
   output logic [15:0] rsp_group_middle,
   output logic [63:0] rsp_value_plus,
   output logic [63:0] rsp_value_minus,
   output logic rsp_poly_done,
   // register port, 64-bit registers at byte 0 and 8
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [3:0] csr_paddr,
   input wire logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   logic [63:0] modulus_ff, eval_point_ff;
   logic csr_wr;
   term_type req_term, q_term;
   logic q_valid, q_ready, back_idle;
   result_type rsp_data;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == REG_EVAL_POINT) ? eval_point_ff : modulus_ff;

   // writes to unmapped addresses are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= 64'd3;
         eval_point_ff <= 64'd1;
      end else if (csr_wr && csr_paddr[2:0] == 3'd0) begin
         if (csr_paddr[3] == REG_MODULUS) modulus_ff <= csr_pwdata;
         else eval_point_ff <= csr_pwdata;
      end
   end

   assign req_term = '{outer: req_term_outer, middle: req_term_middle,
                       inner: req_term_inner, coeff: req_term_coeff, last: req_term_last};

   pepm_front #(.INNER_DEG_MAX(INNER_DEG_MAX), .EXP_FIELD_BITS(EXP_FIELD_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_term(req_term),
      .out_valid(q_valid), .out_ready(q_ready), .out_term(q_term)
   );

   pepm_back u_back (
      .clock, .reset,
      .modulus(modulus_ff), .eval_point(eval_point_ff),
      .table_clear(csr_wr && csr_paddr[2:0] == 3'd0),
      .in_valid(q_valid), .in_ready(q_ready), .in_term(q_term),
      .rsp_valid, .rsp_ready, .rsp_data, .idle(back_idle)
   );

   assign rsp_group_outer = rsp_data.outer;
   assign rsp_group_middle = rsp_data.middle;
   assign rsp_value_plus = rsp_data.value_plus;
   assign rsp_value_minus = rsp_data.value_minus;
   assign rsp_poly_done = rsp_data.done;

   // a held result must not change while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("result changed while held");
   // result values lie below the effective modulus
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && modulus_ff > 64'd1 |-> rsp_value_plus < modulus_ff
      && rsp_value_minus < modulus_ff) else $error("result not reduced");
   // an idle back end leaves nothing pending
   assert property (@(posedge clock) disable iff (reset)
      back_idle |-> !rsp_valid) else $error("idle with result pending");
endmodule
`default_nettype wire
